@@ src/rcpd_pkg.sv @@
// Shared constants and types of the RC PWM frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package rcpd_pkg;

  localparam int NUM_LINES   = 6;
  localparam int LINE_IDX_W  = 3;
  localparam int NUM_ATT     = 4;
  localparam int SLOT_W      = 2;
  localparam int WIDTH_W     = 16;
  localparam int ELAPSED_W   = 20;
  localparam int CMD_W       = 14;
  localparam int ATT_W       = 7;
  localparam int AUX1_W      = 26;
  localparam int AUX2_W      = 25;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  localparam int JOB_FIFO_DEPTH = 2;
  localparam int JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);
  localparam int JOB_CNT_W      = $clog2(JOB_FIFO_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_MAX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_TO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_TO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 3'd4;

  localparam logic [LINE_IDX_W-1:0] SLOW_LINE = 3'd2;
  localparam logic [LINE_IDX_W-1:0] LAST_LINE = 3'(NUM_LINES - 1);

  localparam logic [WIDTH_W-1:0] MIN_KEEP = 16'd950;
  localparam logic [WIDTH_W-1:0] LOW_OK   = 16'd1000;
  localparam logic [WIDTH_W-1:0] HIGH_OK  = 16'd2000;

  // Division by 820 is done as a shift by two and a multiply by ceil(2^28/205).
  localparam logic [21:0] RECIP_205 = 22'd1309442;
  localparam int          RECIP_SH  = 28;

  typedef struct packed {
    logic [11:0]           throttle_max;
    logic [11:0]           throttle_min;
    logic [ELAPSED_W-1:0]  stage_timeout;
    logic [ELAPSED_W-1:0]  slow_stage_timeout;
    logic [3:0]            deadband;
  } cfg_t;

  // One unit of work for the back end: a finished frame or a timeout.
  typedef struct packed {
    logic                                timeout;
    logic [NUM_LINES-1:0][WIDTH_W-1:0]   width;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

endpackage

`default_nettype wire

@@ src/rc_pwm_frame_decoder_top.sv @@
// Top level of the RC PWM frame decoder: configuration registers and submodule wiring.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_line_levels      | request in
//   out     | out_valid, out_ready, out_status, cmds  | request out
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata         | write only
//
// One tick request is taken every cycle while the job queue (two entries) has room.
// In the back end a timeout result goes straight to emit, a frame result through commit, four
// multiply/divide pairs for the stick map (one shared map multiplier) and emit.
// Reset is synchronous and active low; it restores register defaults and arming.
// A stalled output holds its result while the front keeps taking ticks until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module rc_pwm_frame_decoder_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [rcpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rcpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rcpd_pkg::NUM_LINES-1:0]   in_line_levels,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_status,
  output logic signed [rcpd_pkg::ATT_W-1:0]     out_roll_cmd,
  output logic signed [rcpd_pkg::CMD_W-1:0]     out_throttle_cmd,
  output logic signed [rcpd_pkg::ATT_W-1:0]     out_pitch_cmd,
  output logic signed [rcpd_pkg::ATT_W-1:0]     out_yaw_cmd,
  output logic signed [rcpd_pkg::AUX1_W-1:0]    out_aux1_coeff,
  output logic signed [rcpd_pkg::AUX2_W-1:0]    out_aux2_coeff
);

  rcpd_pkg::cfg_t       cfg_r;
  rcpd_pkg::job_push_t  push;
  rcpd_pkg::job_t       q_head;
  logic                 q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_max       <= 12'd1000;
      cfg_r.throttle_min       <= 12'd0;
      cfg_r.stage_timeout      <= 20'd100000;
      cfg_r.slow_stage_timeout <= 20'd1000000;
      cfg_r.deadband           <= 4'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rcpd_pkg::CFG_THROTTLE_MAX: cfg_r.throttle_max       <= cfg_wdata[11:0];
        rcpd_pkg::CFG_THROTTLE_MIN: cfg_r.throttle_min       <= cfg_wdata[11:0];
        rcpd_pkg::CFG_STAGE_TO:     cfg_r.stage_timeout      <= cfg_wdata;
        rcpd_pkg::CFG_SLOW_TO:      cfg_r.slow_stage_timeout <= cfg_wdata;
        rcpd_pkg::CFG_DEADBAND:     cfg_r.deadband           <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  rcpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_line_levels (in_line_levels),
    .q_full         (q_full),
    .push           (push)
  );

  rcpd_job_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  rcpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_roll_cmd     (out_roll_cmd),
    .out_throttle_cmd (out_throttle_cmd),
    .out_pitch_cmd    (out_pitch_cmd),
    .out_yaw_cmd      (out_yaw_cmd),
    .out_aux1_coeff   (out_aux1_coeff),
    .out_aux2_coeff   (out_aux2_coeff)
  );

endmodule

`default_nettype wire

@@ src/rcpd_front.sv @@
// Front end: per-tick pulse tracking, interval counting and timeout detection.
`timescale 1ns / 1ps
`default_nettype none

module rcpd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rcpd_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rcpd_pkg::NUM_LINES-1:0] in_line_levels,
  input  wire logic                          q_full,
  output rcpd_pkg::job_push_t                push
);

  typedef enum logic [2:0] {
    F_ARM  = 3'b001,
    F_RISE = 3'b010,
    F_FALL = 3'b100
  } front_state_t;

  front_state_t                          state_r, state_nxt;
  logic [rcpd_pkg::LINE_IDX_W-1:0]       line_r, line_nxt;
  logic [rcpd_pkg::ELAPSED_W-1:0]        elapsed_r, elapsed_nxt, elapsed_inc;
  logic [rcpd_pkg::WIDTH_W-1:0]          interval_r, interval_nxt, interval_inc;
  logic [rcpd_pkg::NUM_LINES-2:0][rcpd_pkg::WIDTH_W-1:0] pending_r, pending_nxt;
  logic [rcpd_pkg::ELAPSED_W-1:0]        limit;
  logic                                  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign elapsed_inc  = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign interval_inc = (interval_r == '1) ? interval_r : interval_r + 1'b1;
  assign limit = (line_r == rcpd_pkg::SLOW_LINE) ? cfg.slow_stage_timeout
                                                 : cfg.stage_timeout;

  always_comb begin
    state_nxt    = state_r;
    line_nxt     = line_r;
    elapsed_nxt  = elapsed_r;
    interval_nxt = interval_r;
    pending_nxt  = pending_r;
    push.valid   = 1'b0;
    push.job.timeout = 1'b0;
    // The last line's interval closes the frame and lands in the top slot.
    push.job.width   = {interval_inc, pending_r};
    if (accept) begin
      case (state_r)
        F_ARM: begin
          if (!in_line_levels[0]) begin
            elapsed_nxt  = '0;
            interval_nxt = '0;
            line_nxt     = '0;
            state_nxt    = F_RISE;
          end
        end
        F_RISE: begin
          elapsed_nxt  = elapsed_inc;
          interval_nxt = interval_inc;
          if (in_line_levels[line_r]) begin
            // The interval that ends here belongs to the previous line.
            if (line_r != '0) begin
              pending_nxt[line_r - 1'b1] = interval_inc;
            end
            interval_nxt = '0;
            if (line_r == rcpd_pkg::LAST_LINE) begin
              state_nxt = F_FALL;
            end else begin
              line_nxt = line_r + 1'b1;
            end
          end else if (elapsed_inc > limit) begin
            push.valid       = 1'b1;
            push.job.timeout = 1'b1;
            state_nxt        = F_ARM;
          end
        end
        F_FALL: begin
          elapsed_nxt  = elapsed_inc;
          interval_nxt = interval_inc;
          if (!in_line_levels[rcpd_pkg::LAST_LINE]) begin
            push.valid = 1'b1;
            state_nxt  = F_ARM;
          end
        end
        default: begin
          state_nxt = F_ARM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_ARM;
      line_r     <= '0;
      elapsed_r  <= '0;
      interval_r <= '0;
    end else begin
      state_r    <= state_nxt;
      line_r     <= line_nxt;
      elapsed_r  <= elapsed_nxt;
      interval_r <= interval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pending_r <= pending_nxt;
  end

endmodule

`default_nettype wire

@@ src/rcpd_job_fifo.sv @@
// Short queue of frame and timeout jobs between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module rcpd_job_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rcpd_pkg::job_push_t push,
  output logic                     full,
  input  wire logic                pop,
  output rcpd_pkg::job_t           head,
  output logic                     empty
);

  rcpd_pkg::job_t                     mem_r [rcpd_pkg::JOB_FIFO_DEPTH];
  logic [rcpd_pkg::JOB_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [rcpd_pkg::JOB_CNT_W-1:0]     count_r;
  logic                               do_push, do_pop;

  assign full    = (count_r == rcpd_pkg::JOB_CNT_W'(rcpd_pkg::JOB_FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

`default_nettype wire

@@ src/rcpd_back.sv @@
// Back end: width commit, stick mapping, deadband, aux coefficients and result register.
`timescale 1ns / 1ps
`default_nettype none

module rcpd_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire rcpd_pkg::cfg_t                 cfg,
  input  wire logic                           q_empty,
  input  wire rcpd_pkg::job_t                 q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_status,
  output logic signed [rcpd_pkg::ATT_W-1:0]   out_roll_cmd,
  output logic signed [rcpd_pkg::CMD_W-1:0]   out_throttle_cmd,
  output logic signed [rcpd_pkg::ATT_W-1:0]   out_pitch_cmd,
  output logic signed [rcpd_pkg::ATT_W-1:0]   out_yaw_cmd,
  output logic signed [rcpd_pkg::AUX1_W-1:0]  out_aux1_coeff,
  output logic signed [rcpd_pkg::AUX2_W-1:0]  out_aux2_coeff
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_DIV  = 4'b0100,
    B_EMIT = 4'b1000
  } back_state_t;

  back_state_t                       state_r, state_nxt;
  logic [rcpd_pkg::SLOT_W-1:0]       slot_r, slot_nxt;
  logic                              timeout_r, timeout_nxt;
  logic [rcpd_pkg::NUM_LINES-1:0][rcpd_pkg::WIDTH_W-1:0] raw_r, raw_nxt;
  logic [rcpd_pkg::NUM_ATT-1:0][rcpd_pkg::CMD_W-1:0]     held_r, held_nxt;

  // Map pipeline registers.
  logic signed [23:0]                num_r, num_nxt;
  logic                              in_range_r, in_range_nxt;
  logic                              low_r, low_nxt;

  logic [rcpd_pkg::WIDTH_W-1:0]      w_sel;
  logic signed [16:0]                diff17;
  logic signed [10:0]                diff11;
  logic signed [12:0]                span;
  logic [23:0]                       mag;
  logic [41:0]                       prod;
  logic [rcpd_pkg::CMD_W-1:0]        quot;
  logic signed [rcpd_pkg::CMD_W-1:0] quot_s;
  logic signed [rcpd_pkg::CMD_W-1:0] lo;
  logic signed [rcpd_pkg::CMD_W-1:0] mapped;

  logic signed [17:0]                d4, d5;
  logic signed [27:0]                p4, p5, aux1;
  logic                              load_out;
  logic                              out_valid_r, out_valid_nxt;

  function automatic logic [rcpd_pkg::ATT_W-1:0] dead_zone(
    input logic [rcpd_pkg::CMD_W-1:0] v,
    input logic [3:0]                 db
  );
    logic [rcpd_pkg::CMD_W-1:0] m;
    m = v[rcpd_pkg::CMD_W-1] ? rcpd_pkg::CMD_W'(-v) : v;
    return (m > rcpd_pkg::CMD_W'(db)) ? v[rcpd_pkg::ATT_W-1:0] : '0;
  endfunction

  // Multiply stage of the linear map: (w - 1060) * (hi - lo).
  assign w_sel  = raw_r[slot_r];
  assign diff17 = signed'({1'b0, w_sel}) - 17'sd1060;
  assign diff11 = diff17[10:0];

  always_comb begin
    case (slot_r)
      2'd0:    begin span = -13'sd90; lo = 14'sd45;  end
      2'd1:    begin span = signed'({1'b0, cfg.throttle_max}); lo = 14'sd0; end
      2'd2:    begin span = 13'sd90;  lo = -14'sd45; end
      default: begin span = -13'sd40; lo = 14'sd20;  end
    endcase
  end

  // Divide stage: truncate toward zero by dividing the magnitude.
  assign mag    = num_r[23] ? 24'(-num_r) : 24'(num_r);
  assign prod   = 42'(mag[21:2]) * 42'(rcpd_pkg::RECIP_205);
  assign quot   = prod[rcpd_pkg::RECIP_SH + rcpd_pkg::CMD_W - 1:rcpd_pkg::RECIP_SH];
  assign quot_s = num_r[23] ? -signed'(quot) : signed'(quot);
  assign mapped = quot_s + lo;

  // Aux coefficients from the committed widths.
  assign d4   = signed'({2'b0, raw_r[4]}) - 18'sd1000;
  assign d5   = signed'({2'b0, raw_r[5]}) - 18'sd1000;
  assign p4   = 28'(d4) * 28'sd300;
  assign p5   = 28'(d5) * 28'sd200;
  assign aux1 = 28'sd300000 - p4;

  assign load_out  = (state_r == B_EMIT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    timeout_nxt  = timeout_r;
    raw_nxt      = raw_r;
    held_nxt     = held_r;
    num_nxt      = num_r;
    in_range_nxt = in_range_r;
    low_nxt      = low_r;
    q_pop        = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          timeout_nxt = q_head.timeout;
          slot_nxt    = '0;
          if (q_head.timeout) begin
            state_nxt = B_EMIT;
          end else begin
            // Commit: only widths above the keep threshold replace the old ones.
            for (int l = 0; l < rcpd_pkg::NUM_LINES; l++) begin
              if (q_head.width[l] > rcpd_pkg::MIN_KEEP) begin
                raw_nxt[l] = q_head.width[l];
              end
            end
            state_nxt = B_MUL;
          end
        end
      end
      B_MUL: begin
        num_nxt      = diff11 * span;
        in_range_nxt = (w_sel > rcpd_pkg::LOW_OK) && (w_sel < rcpd_pkg::HIGH_OK);
        low_nxt      = (w_sel < rcpd_pkg::LOW_OK);
        state_nxt    = B_DIV;
      end
      B_DIV: begin
        if (in_range_r) begin
          held_nxt[slot_r] = mapped;
        end else if (low_r && (slot_r == 2'd1)) begin
          // A throttle pulse below the valid window cuts the throttle.
          held_nxt[slot_r] = rcpd_pkg::CMD_W'(cfg.throttle_min);
        end
        if (slot_r == rcpd_pkg::SLOT_W'(rcpd_pkg::NUM_ATT - 1)) begin
          state_nxt = B_EMIT;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = B_MUL;
        end
      end
      B_EMIT: begin
        if (load_out) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      slot_r      <= '0;
      timeout_r   <= 1'b0;
      raw_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      timeout_r   <= timeout_nxt;
      raw_r       <= raw_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    in_range_r <= in_range_nxt;
    low_r      <= low_nxt;
    if (load_out) begin
      out_status       <= timeout_r;
      out_roll_cmd     <= signed'(dead_zone(held_r[0], cfg.deadband));
      out_throttle_cmd <= signed'(held_r[1]);
      out_pitch_cmd    <= signed'(dead_zone(held_r[2], cfg.deadband));
      out_yaw_cmd      <= signed'(dead_zone(held_r[3], cfg.deadband));
      out_aux1_coeff   <= aux1[rcpd_pkg::AUX1_W-1:0];
      out_aux2_coeff   <= p5[rcpd_pkg::AUX2_W-1:0];
    end
  end

endmodule

`default_nettype wire
